/* rtl/shared_dual_stack_defines.svh */
// ============================================================================
// shared_dual_stack_defines.svh
// Assertion macros shared by the shared dual stack RTL.
// ============================================================================
`ifndef SHARED_DUAL_STACK_DEFINES_SVH
`define SHARED_DUAL_STACK_DEFINES_SVH

// Property checked on every clock edge, masked while reset is asserted.
`define SDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/sds_pkg.sv */
// ============================================================================
// sds_pkg
// Types, codes and default sizes for the shared dual stack.
// ============================================================================
`default_nettype none

package sds_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } sds_op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_ACCESS = 2'd1,
        S_RESULT = 2'd2
    } sds_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;  // latch request fields
        logic access;   // memory access and pointer update
        logic load;     // load result register
    } sds_cmd_t;

endpackage

`default_nettype wire

/* rtl/shared_dual_stack.sv */
// ============================================================================
// shared_dual_stack
// Two stacks in one word memory: low stack grows up, high stack grows down.
// ============================================================================
// Usage:
//   Input channel (s_): one beat is one request. s_tuser carries the
//   operation (push, pop, peek, clear) and the stack select; s_tdata carries
//   the word to push. Output channel (m_): one result beat per request with
//   the status in m_tuser and the word read plus both stack lengths in
//   m_tdata.
//   Sequence: an accepted beat moves through the access step (single port
//   memory, registered read) and the result load; no new request is taken
//   until the sequencer has walked accept, access and result load.
//   Stall: the result register holds its beat while m_tready is low; the
//   next request is still taken and stops in its result step until the
//   register is free.
//   Reset: aresetn low empties both stacks and drops m_tvalid. Memory
//   contents are not cleared; words above a stack top are never read.
// ============================================================================
`default_nettype none

module shared_dual_stack #(
    parameter int DEPTH     = sds_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sds_pkg::WORD_BITS_DEF,
    localparam int LW       = $clog2(DEPTH + 1),
    localparam int S_DW     = ((WORD_BITS + 7) / 8) * 8,
    localparam int M_DW     = ((WORD_BITS + 2 * LW + 7) / 8) * 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [S_DW-1:0] s_tdata,   // push_value
    input  wire logic [2:0]      s_tuser,   // req_type[1:0], stack_sel[2]
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [M_DW-1:0]      m_tdata,   // read_value, low_length, high_length
    output logic [1:0]           m_tuser    // status
);
    import sds_pkg::*;

    sds_cmd_t                    cmd;
    logic [1:0]                  status;
    logic signed [WORD_BITS-1:0] read_value;
    logic [LW-1:0]               low_length;
    logic [LW-1:0]               high_length;

    sds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sds_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .req_type    (s_tuser[1:0]),
        .stack_sel   (s_tuser[2]),
        .push_value  (signed'(s_tdata[WORD_BITS-1:0])),
        .status      (status),
        .read_value  (read_value),
        .low_length  (low_length),
        .high_length (high_length)
    );

    assign m_tuser = status;
    assign m_tdata = M_DW'({high_length, low_length, read_value});

endmodule

`default_nettype wire

/* rtl/sds_ctrl.sv */
// ============================================================================
// sds_ctrl
// Request sequencer: accept, access, result; owns the result valid flag.
// ============================================================================
`default_nettype none

`include "shared_dual_stack_defines.svh"

module sds_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output sds_pkg::sds_cmd_t      cmd
);
    import sds_pkg::*;

    sds_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_ACCESS;
            end
            S_ACCESS: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                // wait for the result register to free up
                if (!m_valid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.access  = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_ACCESS: begin
                cmd.access = 1'b1;
            end
            S_RESULT: begin
                cmd.load = !m_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    `SDS_ASSERT(a_load_no_overwrite, cmd.load |-> (!m_valid_reg || m_tready), "result overwritten while stalled")
    `SDS_ASSERT(a_load_sets_valid, cmd.load |=> m_valid_reg, "loaded result not presented")
    `SDS_ASSERT(a_access_then_result, (state_reg == S_ACCESS) |=> (state_reg == S_RESULT), "access not followed by result")
    `SDS_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "new beat taken during access")
    `SDS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == S_IDLE && !m_valid_reg), "reset did not idle controller")

endmodule

`default_nettype wire

/* rtl/sds_dpath.sv */
// ============================================================================
// sds_dpath
// Shared word memory, the two stack counters and the result register.
// ============================================================================
`default_nettype none

module sds_dpath #(
    parameter int DEPTH     = sds_pkg::DEPTH_DEF,
    parameter int WORD_BITS = sds_pkg::WORD_BITS_DEF,
    localparam int LW       = $clog2(DEPTH + 1),
    localparam int AW       = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sds_pkg::sds_cmd_t           cmd,
    input  wire logic [1:0]                  req_type,
    input  wire logic                        stack_sel,
    input  wire logic signed [WORD_BITS-1:0] push_value,
    output logic [1:0]                       status,
    output logic signed [WORD_BITS-1:0]      read_value,
    output logic [LW-1:0]                    low_length,
    output logic [LW-1:0]                    high_length
);
    import sds_pkg::*;

    localparam int LW1 = LW + 1;

    // request latch
    sds_op_t                      op_reg;
    logic                         sel_reg;
    logic signed [WORD_BITS-1:0]  val_reg;

    logic [LW-1:0] low_reg, low_next;
    logic [LW-1:0] high_reg, high_next;

    logic [WORD_BITS-1:0] word_store_reg [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [1:0] st_reg, st_next;
    logic       rd_ok_reg, rd_ok_next;

    logic [1:0]                  out_status_reg;
    logic signed [WORD_BITS-1:0] out_value_reg;
    logic [LW-1:0]               out_low_reg;
    logic [LW-1:0]               out_high_reg;

    logic          full;
    logic          empty;
    logic          we;
    logic          re;
    logic [LW-1:0] addr;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= sds_op_t'(req_type);
            sel_reg <= stack_sel;
            val_reg <= push_value;
        end
    end

    assign full  = (LW1'(low_reg) + LW1'(high_reg)) >= LW1'(DEPTH);
    assign empty = sel_reg ? (high_reg == '0) : (low_reg == '0);

    always_comb begin
        low_next   = low_reg;
        high_next  = high_reg;
        st_next    = ST_OK;
        rd_ok_next = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        addr       = '0;
        unique case (op_reg) inside
            OP_PUSH: begin
                if (full) begin
                    st_next = ST_FULL;
                end else if (!sel_reg) begin
                    we       = 1'b1;
                    addr     = low_reg;
                    low_next = low_reg + LW'(1);
                end else begin
                    we        = 1'b1;
                    addr      = LW'(DEPTH - 1) - high_reg;
                    high_next = high_reg + LW'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (empty) begin
                    st_next = ST_EMPTY;
                end else begin
                    re         = 1'b1;
                    rd_ok_next = 1'b1;
                    addr       = sel_reg ? (LW'(DEPTH) - high_reg) : (low_reg - LW'(1));
                    if (op_reg == OP_POP) begin
                        if (sel_reg) high_next = high_reg - LW'(1);
                        else         low_next  = low_reg - LW'(1);
                    end
                end
            end
            OP_CLEAR: begin
                if (sel_reg) high_next = '0;
                else         low_next  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '0;
        end else if (cmd.access) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            st_reg    <= st_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    // single-port memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.access && we) word_store_reg[addr[AW-1:0]] <= val_reg;
        if (cmd.access && re) rd_data_reg <= word_store_reg[addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= st_reg;
            out_value_reg  <= rd_ok_reg ? signed'(rd_data_reg) : '0;
            out_low_reg    <= low_reg;
            out_high_reg   <= high_reg;
        end
    end

    assign status      = out_status_reg;
    assign read_value  = out_value_reg;
    assign low_length  = out_low_reg;
    assign high_length = out_high_reg;

endmodule

`default_nettype wire
